// File: rtl/core/tshc_pkg.sv
// ----------------------------------------------------------------------------
// tshc_pkg
// Shared types and constants of the transport stream header checker.
// ----------------------------------------------------------------------------
package tshc_pkg;

  // packet geometry
  localparam int unsigned PacketSize = 188;
  localparam int unsigned PidWidth   = 13;
  localparam int unsigned PidCount   = 1 << PidWidth;

  localparam logic [7:0]          SyncValue        = 8'h47;
  localparam logic [PidWidth-1:0] NullPid          = 13'h1FFF;
  localparam logic [4:0]          NoPayload        = 5'h10;
  localparam logic [7:0]          HeaderOnlyOffset = 8'd4;
  localparam logic [7:0]          HeaderOnlySize   = 8'(PacketSize - 4);
  localparam logic [7:0]          AdaptOnlyMaxLen  = 8'(PacketSize - 5);
  localparam logic [7:0]          AdaptBothMaxLen  = 8'(PacketSize - 6);
  localparam logic [7:0]          AdaptBothBase    = 8'(PacketSize - 5);
  localparam logic [7:0]          AdaptHeaderLen   = 8'd5;

  // adaptation field control codes
  localparam logic [1:0] ActlReserved    = 2'd0;
  localparam logic [1:0] ActlPayloadOnly = 2'd1;
  localparam logic [1:0] ActlAdaptOnly   = 2'd2;
  localparam logic [1:0] ActlBoth        = 2'd3;

  // scrambling control code that is reserved
  localparam logic [1:0] ScrReserved = 2'd1;

  // result status codes
  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StFormat     = 2'd1,
    StTransport  = 2'd2,
    StContinuity = 2'd3
  } status_e;

  // decoded header, handed from front to back
  typedef struct packed {
    status_e             status;
    logic [PidWidth-1:0] pid;
    logic                unit_start;
    logic                priority_bit;
    logic [1:0]          scr;
    logic [1:0]          actl;
    logic [3:0]          cc;
    logic [7:0]          alen;
    logic [7:0]          aflags;
    logic [7:0]          poff;
    logic [7:0]          psize;
    logic                upd;
    logic [4:0]          new_entry;
  } hdr_t;

endpackage

// File: rtl/core/tshc_front.sv
// ----------------------------------------------------------------------------
// tshc_front
// Accepts header beats, decodes fields and classifies format errors.
// ----------------------------------------------------------------------------
module tshc_front (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       header_byte0_i,
  input  logic [7:0]       header_byte1_i,
  input  logic [7:0]       header_byte2_i,
  input  logic [7:0]       header_byte3_i,
  input  logic [7:0]       header_byte4_i,
  input  logic [7:0]       header_byte5_i,
  input  logic             track_continuity_i,
  input  logic             busy_i,
  input  logic             queue_full_i,
  output logic             push_o,
  output tshc_pkg::hdr_t   hdr_o
);

  logic [tshc_pkg::PidWidth-1:0] pid;
  logic [1:0]                    scr;
  logic [1:0]                    actl;
  logic [7:0]                    alen;
  logic                          pid_reserved;

  // handshake: hold off during table clear or when the queue is full
  assign in_stall_o = busy_i || queue_full_i;
  assign push_o     = in_valid_i && !in_stall_o;

  // field split
  assign pid  = {header_byte1_i[4:0], header_byte2_i};
  assign scr  = header_byte3_i[7:6];
  assign actl = header_byte3_i[5:4];
  assign alen = actl[1] ? header_byte4_i : 8'd0;
  assign pid_reserved = (pid >= 13'd2) && (pid <= 13'd15);

  always_comb begin
    hdr_o              = '0;
    hdr_o.pid          = pid;
    hdr_o.unit_start   = header_byte1_i[6];
    hdr_o.priority_bit = header_byte1_i[5];
    hdr_o.scr          = scr;
    hdr_o.actl         = actl;
    hdr_o.cc           = header_byte3_i[3:0];
    hdr_o.alen         = alen;
    hdr_o.aflags       = (alen != 8'd0) ? header_byte5_i : 8'd0;

    // payload position and size
    hdr_o.poff  = 8'd0;
    hdr_o.psize = 8'd0;
    if (actl == tshc_pkg::ActlPayloadOnly) begin
      hdr_o.poff  = tshc_pkg::HeaderOnlyOffset;
      hdr_o.psize = tshc_pkg::HeaderOnlySize;
    end else if (actl == tshc_pkg::ActlBoth && alen <= tshc_pkg::AdaptBothMaxLen) begin
      hdr_o.poff  = alen + tshc_pkg::AdaptHeaderLen;
      hdr_o.psize = tshc_pkg::AdaptBothBase - alen;
    end

    // status in priority order
    if (header_byte0_i != tshc_pkg::SyncValue) begin
      hdr_o.status = tshc_pkg::StFormat;
    end else if (header_byte1_i[7]) begin
      hdr_o.status = tshc_pkg::StTransport;
    end else if (pid_reserved || scr == tshc_pkg::ScrReserved
                 || actl == tshc_pkg::ActlReserved) begin
      hdr_o.status = tshc_pkg::StFormat;
    end else if (actl == tshc_pkg::ActlAdaptOnly && alen > tshc_pkg::AdaptOnlyMaxLen) begin
      hdr_o.status = tshc_pkg::StFormat;
    end else if (actl == tshc_pkg::ActlBoth && alen > tshc_pkg::AdaptBothMaxLen) begin
      hdr_o.status = tshc_pkg::StFormat;
    end else begin
      hdr_o.status = tshc_pkg::StOk;
    end

    // continuity table work for the back end
    hdr_o.upd = (hdr_o.status == tshc_pkg::StOk) && track_continuity_i
                && (pid != tshc_pkg::NullPid);
    hdr_o.new_entry = actl[0] ? {1'b0, header_byte3_i[3:0]} : tshc_pkg::NoPayload;
  end

endmodule

// File: rtl/core/tshc_queue.sv
// ----------------------------------------------------------------------------
// tshc_queue
// Short first-in first-out queue of decoded headers between front and back.
// ----------------------------------------------------------------------------
module tshc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tshc_pkg::hdr_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           not_empty_o,
  output tshc_pkg::hdr_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  tshc_pkg::hdr_t  slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o      = (count_q == FullCnt);
  assign not_empty_o = (count_q != '0);
  assign pop_data_o  = slot_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/tshc_back.sv
// ----------------------------------------------------------------------------
// tshc_back
// Continuity table read-modify-write with forwarding, and the result register.
// ----------------------------------------------------------------------------
module tshc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_not_empty_i,
  input  tshc_pkg::hdr_t q_data_i,
  output logic           pop_o,
  output logic           busy_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output tshc_pkg::hdr_t out_hdr_o
);

  localparam int unsigned PidW = tshc_pkg::PidWidth;

  logic [4:0]      table_mem [tshc_pkg::PidCount];

  // clear sweep after reset
  logic            clearing_q;
  logic [PidW-1:0] clr_addr_q;

  // lookup stage
  logic            b_valid_q;
  tshc_pkg::hdr_t  b_q;
  logic [4:0]      rd_q;
  logic            b_adv;
  logic [4:0]      old_entry;
  logic            cc_bad;
  tshc_pkg::hdr_t  b_res;

  // last table write, for a read issued in the same cycle
  logic            fwd_valid_q;
  logic [PidW-1:0] fwd_addr_q;
  logic [4:0]      fwd_data_q;

  // result register
  logic            out_valid_q;
  tshc_pkg::hdr_t  out_q;
  logic            out_ready;

  // table write port
  logic            we;
  logic [PidW-1:0] waddr;
  logic [4:0]      wdata;

  assign busy_o    = clearing_q;
  assign out_ready = !out_valid_q || !out_stall_i;
  assign b_adv     = b_valid_q && out_ready;
  assign pop_o     = q_not_empty_i && !clearing_q && (!b_valid_q || b_adv);

  // continuity compare on the old entry
  assign old_entry = (fwd_valid_q && fwd_addr_q == b_q.pid) ? fwd_data_q : rd_q;
  assign cc_bad    = b_q.upd && !b_q.aflags[7] && !old_entry[4] && !b_q.new_entry[4]
                     && ((old_entry[3:0] + 4'd1) != b_q.new_entry[3:0]);

  always_comb begin
    b_res = b_q;
    if (cc_bad) begin
      b_res.status = tshc_pkg::StContinuity;
    end
  end

  assign we    = clearing_q || (b_adv && b_q.upd);
  assign waddr = clearing_q ? clr_addr_q : b_q.pid;
  assign wdata = clearing_q ? tshc_pkg::NoPayload : b_q.new_entry;

  // clear sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      table_mem[waddr] <= wdata;
    end
    if (pop_o) begin
      rd_q <= table_mem[q_data_i.pid];
    end
  end

  // lookup stage and forward register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv && b_q.upd) begin
        fwd_valid_q <= 1'b1;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_q <= q_data_i;
    end
    if (b_adv && b_q.upd) begin
      fwd_addr_q <= b_q.pid;
      fwd_data_q <= b_q.new_entry;
    end
    if (b_adv) begin
      out_q <= b_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hdr_o   = out_q;

endmodule

// File: rtl/core/ts_header_check.sv
// ----------------------------------------------------------------------------
// ts_header_check
// Transport stream header decoder with per-PID continuity checking.
// ----------------------------------------------------------------------------
// path: an accepted header beat passes the queue, the lookup stage and the result register
// throughput: one beat per cycle, set by the table read-modify-write, while the output is not stalled
// reset: a clear sweep writes all 8192 table entries, one per cycle, and
//   in_stall_o stays high until the sweep is done
module ts_header_check #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  header_byte0_i,
  input  logic [7:0]  header_byte1_i,
  input  logic [7:0]  header_byte2_i,
  input  logic [7:0]  header_byte3_i,
  input  logic [7:0]  header_byte4_i,
  input  logic [7:0]  header_byte5_i,
  input  logic        track_continuity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [12:0] packet_id_o,
  output logic        unit_start_o,
  output logic        transport_priority_o,
  output logic [1:0]  scrambling_ctrl_o,
  output logic [1:0]  adaptation_ctrl_o,
  output logic [3:0]  continuity_count_o,
  output logic [7:0]  adaptation_length_o,
  output logic [7:0]  adaptation_flags_o,
  output logic [7:0]  payload_offset_o,
  output logic [7:0]  payload_size_o
);

  logic           busy;
  logic           queue_full;
  logic           push;
  tshc_pkg::hdr_t front_hdr;
  logic           pop;
  logic           q_not_empty;
  tshc_pkg::hdr_t q_hdr;
  tshc_pkg::hdr_t out_hdr;

  // decode and classify
  tshc_front u_front (
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .header_byte0_i     (header_byte0_i),
    .header_byte1_i     (header_byte1_i),
    .header_byte2_i     (header_byte2_i),
    .header_byte3_i     (header_byte3_i),
    .header_byte4_i     (header_byte4_i),
    .header_byte5_i     (header_byte5_i),
    .track_continuity_i (track_continuity_i),
    .busy_i             (busy),
    .queue_full_i       (queue_full),
    .push_o             (push),
    .hdr_o              (front_hdr)
  );

  // decoupling queue
  tshc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_hdr),
    .full_o      (queue_full),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .pop_data_o  (q_hdr)
  );

  // continuity table and result register
  tshc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_data_i      (q_hdr),
    .pop_o         (pop),
    .busy_o        (busy),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_hdr_o     (out_hdr)
  );

  assign status_o             = out_hdr.status;
  assign packet_id_o          = out_hdr.pid;
  assign unit_start_o         = out_hdr.unit_start;
  assign transport_priority_o = out_hdr.priority_bit;
  assign scrambling_ctrl_o    = out_hdr.scr;
  assign adaptation_ctrl_o    = out_hdr.actl;
  assign continuity_count_o   = out_hdr.cc;
  assign adaptation_length_o  = out_hdr.alen;
  assign adaptation_flags_o   = out_hdr.aflags;
  assign payload_offset_o     = out_hdr.poff;
  assign payload_size_o       = out_hdr.psize;

endmodule

// File: rtl/core/tshc_checker.sv
// ----------------------------------------------------------------------------
// tshc_checker
// Port-level checks of the transport stream header checker.
// ----------------------------------------------------------------------------
module tshc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [12:0] packet_id_o,
  input logic [1:0]  adaptation_ctrl_o,
  input logic [7:0]  adaptation_length_o,
  input logic [7:0]  adaptation_flags_o,
  input logic [7:0]  payload_offset_o,
  input logic [7:0]  payload_size_o
);

  // a stalled result beat stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
                                  && $stable(packet_id_o))
    else $error("stalled result beat changed");

  // flags are zero without an adaptation field body
  a_flags_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && adaptation_length_o == 8'd0 |-> adaptation_flags_o == 8'd0)
    else $error("adaptation flags set with zero length");

  // payload-only packets have a fixed payload window
  a_payload_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && adaptation_ctrl_o == tshc_pkg::ActlPayloadOnly
    |-> payload_offset_o == tshc_pkg::HeaderOnlyOffset
        && payload_size_o == tshc_pkg::HeaderOnlySize)
    else $error("bad payload window for payload-only packet");

  // a continuity error is never flagged across a discontinuity
  a_cc_discont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == tshc_pkg::StContinuity |-> !adaptation_flags_o[7])
    else $error("continuity error despite discontinuity flag");

endmodule

bind ts_header_check tshc_checker u_tshc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .status_o            (status_o),
  .packet_id_o         (packet_id_o),
  .adaptation_ctrl_o   (adaptation_ctrl_o),
  .adaptation_length_o (adaptation_length_o),
  .adaptation_flags_o  (adaptation_flags_o),
  .payload_offset_o    (payload_offset_o),
  .payload_size_o      (payload_size_o)
);

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ts_header_check testbench
// Sends transport stream headers through the checker and compares every
// decoded result against a local decoder that keeps its own per-PID
// continuity table. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RandomItems   = 1130;
  localparam int unsigned WatchdogLimit = 50000;
  localparam int unsigned DrainCycles   = 8;

  // reserved PID range and the plain scrambling code
  localparam logic [tshc_pkg::PidWidth-1:0] ReservedPidLo = 13'd2;
  localparam logic [tshc_pkg::PidWidth-1:0] ReservedPidHi = 13'd15;
  localparam logic [1:0]                    ScrClear      = 2'd0;

  // one header beat as it enters the block
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic       track;
  } hdr_beat_t;

  // one decoded header as it leaves the block
  typedef struct packed {
    tshc_pkg::status_e             status;
    logic [tshc_pkg::PidWidth-1:0] pid;
    logic                          unit_start;
    logic                          priority_bit;
    logic [1:0]                    scr;
    logic [1:0]                    actl;
    logic [3:0]                    cc;
    logic [7:0]                    alen;
    logic [7:0]                    aflags;
    logic [7:0]                    poff;
    logic [7:0]                    psize;
  } hdr_result_t;

  // decoder with its own continuity table and a queue of decoded headers
  class header_scoreboard;
    logic [4:0]  cc_table [tshc_pkg::PidCount];
    hdr_result_t decoded_q [$];
    int unsigned errors;

    function new();
      foreach (cc_table[i]) cc_table[i] = tshc_pkg::NoPayload;
      errors = 0;
    endfunction

    function int unsigned pending();
      return decoded_q.size();
    endfunction

    function hdr_result_t decode_header(hdr_beat_t beat);
      hdr_result_t res;
      logic        discont;
      logic [4:0]  old_entry;
      logic [4:0]  new_entry;
      res.pid          = {beat.byte1[4:0], beat.byte2};
      res.unit_start   = beat.byte1[6];
      res.priority_bit = beat.byte1[5];
      res.scr          = beat.byte3[7:6];
      res.actl         = beat.byte3[5:4];
      res.cc           = beat.byte3[3:0];
      res.alen         = res.actl[1] ? beat.byte4 : 8'd0;
      res.aflags       = (res.alen != 8'd0) ? beat.byte5 : 8'd0;
      discont          = res.aflags[7];
      res.poff         = 8'd0;
      res.psize        = 8'd0;
      // payload position
      if (res.actl == tshc_pkg::ActlPayloadOnly) begin
        res.poff  = tshc_pkg::HeaderOnlyOffset;
        res.psize = tshc_pkg::HeaderOnlySize;
      end else if (res.actl == tshc_pkg::ActlBoth && res.alen <= tshc_pkg::AdaptBothMaxLen) begin
        res.poff  = res.alen + tshc_pkg::AdaptHeaderLen;
        res.psize = tshc_pkg::AdaptBothBase - res.alen;
      end
      // status in priority order, table touched only by clean tracked packets
      res.status = tshc_pkg::StOk;
      if (beat.byte0 != tshc_pkg::SyncValue) res.status = tshc_pkg::StFormat;
      else if (beat.byte1[7]) res.status = tshc_pkg::StTransport;
      else if (res.pid >= ReservedPidLo && res.pid <= ReservedPidHi)
        res.status = tshc_pkg::StFormat;
      else if (res.scr == tshc_pkg::ScrReserved) res.status = tshc_pkg::StFormat;
      else if (res.actl == tshc_pkg::ActlReserved) res.status = tshc_pkg::StFormat;
      else if (res.actl == tshc_pkg::ActlAdaptOnly && res.alen > tshc_pkg::AdaptOnlyMaxLen)
        res.status = tshc_pkg::StFormat;
      else if (res.actl == tshc_pkg::ActlBoth && res.alen > tshc_pkg::AdaptBothMaxLen)
        res.status = tshc_pkg::StFormat;
      else if (beat.track && res.pid != tshc_pkg::NullPid) begin
        old_entry = cc_table[res.pid];
        new_entry = res.actl[0] ? {1'b0, res.cc} : tshc_pkg::NoPayload;
        cc_table[res.pid] = new_entry;
        if (!discont && old_entry < tshc_pkg::NoPayload && new_entry < tshc_pkg::NoPayload &&
            old_entry[3:0] + 4'd1 != new_entry[3:0])
          res.status = tshc_pkg::StContinuity;
      end
      return res;
    endfunction

    function void note_header(hdr_beat_t beat);
      decoded_q.push_back(decode_header(beat));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(hdr_result_t got);
      hdr_result_t want;
      if (decoded_q.size() == 0) begin
        $error("result beat with no header pending");
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("packet_id", want.pid, got.pid);
      compare_field("unit_start", want.unit_start, got.unit_start);
      compare_field("transport_priority", want.priority_bit, got.priority_bit);
      compare_field("scrambling_ctrl", want.scr, got.scr);
      compare_field("adaptation_ctrl", want.actl, got.actl);
      compare_field("continuity_count", want.cc, got.cc);
      compare_field("adaptation_length", want.alen, got.alen);
      compare_field("adaptation_flags", want.aflags, got.aflags);
      compare_field("payload_offset", want.poff, got.poff);
      compare_field("payload_size", want.psize, got.psize);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  header_byte0_i;
  logic [7:0]  header_byte1_i;
  logic [7:0]  header_byte2_i;
  logic [7:0]  header_byte3_i;
  logic [7:0]  header_byte4_i;
  logic [7:0]  header_byte5_i;
  logic        track_continuity_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [12:0] packet_id_o;
  logic        unit_start_o;
  logic        transport_priority_o;
  logic [1:0]  scrambling_ctrl_o;
  logic [1:0]  adaptation_ctrl_o;
  logic [3:0]  continuity_count_o;
  logic [7:0]  adaptation_length_o;
  logic [7:0]  adaptation_flags_o;
  logic [7:0]  payload_offset_o;
  logic [7:0]  payload_size_o;

  header_scoreboard sb;
  int unsigned      idle_cycles = 0;
  logic [12:0]      pid_pool [8];
  logic [3:0]       next_cc [8];

  ts_header_check DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .header_byte0_i      (header_byte0_i),
    .header_byte1_i      (header_byte1_i),
    .header_byte2_i      (header_byte2_i),
    .header_byte3_i      (header_byte3_i),
    .header_byte4_i      (header_byte4_i),
    .header_byte5_i      (header_byte5_i),
    .track_continuity_i  (track_continuity_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .packet_id_o         (packet_id_o),
    .unit_start_o        (unit_start_o),
    .transport_priority_o(transport_priority_o),
    .scrambling_ctrl_o   (scrambling_ctrl_o),
    .adaptation_ctrl_o   (adaptation_ctrl_o),
    .continuity_count_o  (continuity_count_o),
    .adaptation_length_o (adaptation_length_o),
    .adaptation_flags_o  (adaptation_flags_o),
    .payload_offset_o    (payload_offset_o),
    .payload_size_o      (payload_size_o)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic hdr_beat_t mk_hdr(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                       logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                       logic track);
    hdr_beat_t beat;
    beat = {b0, b1, b2, b3, b4, b5, track};
    return beat;
  endfunction

  // mostly well-formed headers on a small PID pool with running counts,
  // some with one defect, some pure noise
  function automatic hdr_beat_t random_header();
    hdr_beat_t   beat;
    int unsigned pick;
    logic [2:0]  slot;
    logic [12:0] pid;
    logic [1:0]  scr;
    logic [1:0]  actl;
    logic [3:0]  cc;
    logic [7:0]  len;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      beat.byte0 = 8'($urandom());
      beat.byte1 = 8'($urandom());
      beat.byte2 = 8'($urandom());
      beat.byte3 = 8'($urandom());
      beat.byte4 = 8'($urandom());
      beat.byte5 = 8'($urandom());
      beat.track = 1'($urandom_range(0, 1));
      return beat;
    end
    slot = 3'($urandom_range(0, 7));
    pid  = pid_pool[slot];
    cc   = next_cc[slot];
    scr  = 2'($urandom_range(0, 3));
    if (scr == tshc_pkg::ScrReserved) scr = ScrClear;
    case ($urandom_range(0, 3))
      0, 1:    actl = tshc_pkg::ActlBoth;
      2:       actl = tshc_pkg::ActlPayloadOnly;
      default: actl = tshc_pkg::ActlAdaptOnly;
    endcase
    if (actl == tshc_pkg::ActlPayloadOnly) len = 8'($urandom());
    else if ($urandom_range(0, 3) == 0) len = 8'($urandom_range(0, tshc_pkg::AdaptBothMaxLen));
    else len = 8'($urandom_range(0, 8));
    beat.byte0 = tshc_pkg::SyncValue;
    beat.byte1 = {1'b0, 1'($urandom()), 1'($urandom()), 5'd0};
    beat.byte5 = 8'($urandom());
    beat.byte5[7] = ($urandom_range(0, 7) == 0);
    beat.track = ($urandom_range(0, 15) != 0);
    // one defect per broken header
    if (pick < 28) begin
      case ($urandom_range(0, 8))
        0: beat.byte0 = 8'($urandom());
        1: beat.byte1[7] = 1'b1;
        2: pid = 13'($urandom_range(ReservedPidLo, ReservedPidHi));
        3: scr = tshc_pkg::ScrReserved;
        4: actl = tshc_pkg::ActlReserved;
        5: begin
          actl = tshc_pkg::ActlAdaptOnly;
          len  = 8'($urandom_range(tshc_pkg::AdaptOnlyMaxLen + 1, 255));
        end
        6: begin
          actl = tshc_pkg::ActlBoth;
          len  = 8'($urandom_range(tshc_pkg::AdaptBothMaxLen + 1, 255));
        end
        7: cc = cc + 4'($urandom_range(1, 15));
        default: pid = tshc_pkg::NullPid;
      endcase
    end
    beat.byte1[4:0] = pid[12:8];
    beat.byte2      = pid[7:0];
    beat.byte3      = {scr, actl, cc};
    beat.byte4      = len;
    if (actl[0]) next_cc[slot] = cc + 4'd1;
    return beat;
  endfunction

  // present one header beat, after an optional gap, until it is taken
  task automatic drive_header(input hdr_beat_t beat, input bit with_gap);
    int unsigned gap;
    gap = with_gap ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    header_byte0_i     <= beat.byte0;
    header_byte1_i     <= beat.byte1;
    header_byte2_i     <= beat.byte2;
    header_byte3_i     <= beat.byte3;
    header_byte4_i     <= beat.byte4;
    header_byte5_i     <= beat.byte5;
    track_continuity_i <= beat.track;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // hold the input side until every decoded header has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // output stall: bursts of random stalls and quiet stretches
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(60, 150)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  // accepted beats on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_header(mk_hdr(header_byte0_i, header_byte1_i, header_byte2_i,
                              header_byte3_i, header_byte4_i, header_byte5_i,
                              track_continuity_i));
      if (out_valid_o && !out_stall_i)
        sb.check_result('{tshc_pkg::status_e'(status_o), packet_id_o, unit_start_o,
                          transport_priority_o, scrambling_ctrl_o, adaptation_ctrl_o,
                          continuity_count_o, adaptation_length_o, adaptation_flags_o,
                          payload_offset_o, payload_size_o});
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    bit steady;
    sb                 = new();
    steady             = 1'b0;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    header_byte0_i     = 8'd0;
    header_byte1_i     = 8'd0;
    header_byte2_i     = 8'd0;
    header_byte3_i     = 8'd0;
    header_byte4_i     = 8'd0;
    header_byte5_i     = 8'd0;
    track_continuity_i = 1'b0;
    foreach (pid_pool[i]) begin
      pid_pool[i] = 13'($urandom_range(16, 8190));
      next_cc[i]  = 4'($urandom());
    end
    pid_pool[0] = 13'h0000;
    pid_pool[1] = 13'h0001;
    pid_pool[2] = 13'h1FFE;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sync byte, transport error and reserved field checks
    drive_header(mk_hdr(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b1);
    drive_header(mk_hdr(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h80, 8'h02, 8'h40, 8'h00, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h00, 8'h02, 8'h10, 8'h00, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h00, 8'h0F, 8'h10, 8'h00, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h60, 8'h01, 8'h1A, 8'h00, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h00, 8'h10, 8'hD0, 8'h00, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h50, 8'h00, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1), 1'b1);
    // adaptation length limits for both adaptation modes
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h20, 8'd183, 8'h55, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h20, 8'd184, 8'h55, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h30, 8'd182, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h30, 8'd183, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h31, 8'd0, 8'hFF, 1'b1), 1'b1);
    // continuity: in order, repeated, skipped, discontinuity, wrap
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h12, 8'h00, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h12, 8'h00, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h15, 8'h00, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h39, 8'd1, 8'h80, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h1F, 8'h00, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h10, 8'h00, 8'h00, 1'b1), 1'b1);
    // null packet, tracking off, highest ordinary PID
    drive_header(mk_hdr(8'h47, 8'h1F, 8'hFF, 8'h17, 8'h00, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h17, 8'h00, 8'h00, 1'b0), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h01, 8'h00, 8'h11, 8'h00, 8'h00, 1'b1), 1'b1);
    drive_header(mk_hdr(8'h47, 8'h1F, 8'hFE, 8'h10, 8'h00, 8'h00, 1'b1), 1'b1);
    wait_drained();

    // random headers, with gap-free stretches and one full drain midway
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i % 100 == 0) pid_pool[3'($urandom_range(0, 7))] = 13'($urandom_range(16, 8190));
      if (i == RandomItems / 2) wait_drained();
      drive_header(random_header(), !steady);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
